@@ rtl/plbc_pkg.sv @@
`default_nettype none

package plbc_pkg;

   // field widths
   localparam int LUX_W      = 20;
   localparam int LEVEL_W    = 16;
   localparam int INDEX_W    = 4;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // product of level delta and lux delta, and divider step count
   localparam int PROD_W    = LEVEL_W + LUX_W;
   localparam int DIV_CNT_W = $clog2(LEVEL_W);

   localparam int MAX_POINTS_DEF = 16;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_LEVEL = 1'b1;

   typedef struct packed {
      logic [LUX_W-1:0]   lux;
      logic [LEVEL_W-1:0] level;
   } point_type;

   typedef struct packed {
      logic wr;
      logic start;
      logic scan_step;
      logic mul;
      logic div_step;
      logic adj;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic hit;
      logic seg_bad;
      logic scan_end;
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/plbc_req_if.sv @@
`default_nettype none

interface plbc_req_if
   import plbc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [INDEX_W-1:0] point_index;
   logic [LUX_W-1:0]   point_lux;
   logic [LEVEL_W-1:0] point_level;
   logic [LUX_W-1:0]   query_lux;

   modport source (
      output valid, operation, point_index, point_lux, point_level, query_lux,
      input  ready
   );

   modport sink (
      input  valid, operation, point_index, point_lux, point_level, query_lux,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/plbc_rsp_if.sv @@
`default_nettype none

interface plbc_rsp_if
   import plbc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] brightness;
   logic               used_default;

   modport source (
      output valid, brightness, used_default,
      input  ready
   );

   modport sink (
      input  valid, brightness, used_default,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/plbc_ctrl.sv @@
`default_nettype none

module plbc_ctrl
   import plbc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_op,
   output logic            req_ready,
   input  wire logic       rsp_ready,
   output logic            rsp_valid,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_ADJ  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_WRITE) begin
                  cmd.wr = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = status.n_zero ? ST_DONE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.hit) begin
               state_in = status.seg_bad ? ST_DONE : ST_MUL;
            end else if (status.scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_ADJ;
            end
         end
         ST_ADJ: begin
            cmd.adj  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/plbc_dp.sv @@
`default_nettype none

module plbc_dp
   import plbc_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  wire logic               clock,
   input  wire cmd_type            cmd,
   output status_type              status,
   input  wire logic [INDEX_W-1:0] point_index,
   input  wire logic [LUX_W-1:0]   point_lux,
   input  wire logic [LEVEL_W-1:0] point_level,
   input  wire logic [LUX_W-1:0]   query_lux,
   input  wire logic [COUNT_W-1:0] point_count,
   input  wire logic [LEVEL_W-1:0] default_level,
   output logic [LEVEL_W-1:0]      rsp_brightness,
   output logic                    rsp_used_default
);

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int CW   = (AW > INDEX_W) ? AW : INDEX_W;

   // point table
   point_type point_mem_ff [MAX_POINTS];
   point_type rd_point_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [CW-1:0] wr_idx_ext;
   logic          wr_ok;

   logic [CNTW-1:0]     n_eff;
   logic [CNTW-1:0]     idx_ff, idx_in, idx_nxt;
   logic [LUX_W-1:0]    lux_ff, lux_in;
   logic [LUX_W-1:0]    x0_ff, x0_in;
   logic [LEVEL_W-1:0]  y0_ff, y0_in;
   logic                dy_neg_ff, dy_neg_in;
   logic [LEVEL_W-1:0]  dy_mag_ff, dy_mag_in;
   logic [LUX_W-1:0]    dx_ff, dx_in;
   logic [LUX_W-1:0]    dl_ff, dl_in;
   logic [LUX_W-1:0]    rem_ff, rem_in;
   logic [LEVEL_W-1:0]  quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [LEVEL_W-1:0]  res_level_ff, res_level_in;
   logic                res_dflt_ff, res_dflt_in;
   logic [LEVEL_W-1:0]  out_level_ff, out_level_in;
   logic                out_dflt_ff, out_dflt_in;

   logic [LEVEL_W:0]    dy_diff, dy_abs;
   logic [PROD_W-1:0]   prod;
   logic [LUX_W+1:0]    trial;
   logic [LEVEL_W:0]    quo_signed, adj_sum;

   assign wr_idx_ext = CW'(point_index);
   assign wr_addr    = wr_idx_ext[AW-1:0];
   assign wr_ok      = int'(point_index) < MAX_POINTS;

   always_comb begin
      if (int'(point_count) > MAX_POINTS) begin
         n_eff = CNTW'(MAX_POINTS);
      end else begin
         n_eff = CNTW'(point_count);
      end
   end

   assign idx_nxt = idx_ff + 1'b1;
   assign rd_addr = cmd.scan_step ? idx_nxt[AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (cmd.wr && wr_ok) begin
         point_mem_ff[wr_addr] <= '{lux: point_lux, level: point_level};
      end
      rd_point_ff <= point_mem_ff[rd_addr];
   end

   // status toward the controller
   assign status.n_zero   = (n_eff == '0);
   assign status.hit      = lux_ff < rd_point_ff.lux;
   assign status.seg_bad  = (idx_ff == '0) || (rd_point_ff.lux <= x0_ff);
   assign status.scan_end = (idx_nxt == n_eff);
   assign status.div_last = (div_cnt_ff == DIV_CNT_W'(LEVEL_W - 1));

   assign dy_diff = {1'b0, rd_point_ff.level} - {1'b0, y0_ff};
   assign dy_abs  = dy_diff[LEVEL_W] ? (~dy_diff + 1'b1) : dy_diff;
   assign prod    = dy_mag_ff * dl_ff;

   // restoring divide step, remainder always below dx
   assign trial = {1'b0, rem_ff, quo_ff[LEVEL_W-1]} - {2'b00, dx_ff};

   assign quo_signed = dy_neg_ff ? (~{1'b0, quo_ff} + 1'b1) : {1'b0, quo_ff};
   assign adj_sum    = {1'b0, y0_ff} + quo_signed;

   always_comb begin
      idx_in       = idx_ff;
      lux_in       = lux_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      dy_neg_in    = dy_neg_ff;
      dy_mag_in    = dy_mag_ff;
      dx_in        = dx_ff;
      dl_in        = dl_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      res_level_in = res_level_ff;
      res_dflt_in  = res_dflt_ff;
      out_level_in = out_level_ff;
      out_dflt_in  = out_dflt_ff;

      if (cmd.start) begin
         lux_in       = query_lux;
         idx_in       = '0;
         res_level_in = default_level;
         res_dflt_in  = 1'b1;
      end

      if (cmd.scan_step) begin
         if (status.hit) begin
            if (status.seg_bad) begin
               res_level_in = default_level;
               res_dflt_in  = 1'b1;
            end else begin
               dy_neg_in = dy_diff[LEVEL_W];
               dy_mag_in = dy_abs[LEVEL_W-1:0];
               dx_in     = rd_point_ff.lux - x0_ff;
               dl_in     = lux_ff - x0_ff;
            end
         end else begin
            x0_in        = rd_point_ff.lux;
            y0_in        = rd_point_ff.level;
            res_level_in = rd_point_ff.level;
            res_dflt_in  = 1'b0;
            idx_in       = idx_nxt;
         end
      end

      if (cmd.mul) begin
         {rem_in, quo_in} = prod;
         div_cnt_in       = '0;
      end

      if (cmd.div_step) begin
         if (!trial[LUX_W+1]) begin
            rem_in = trial[LUX_W-1:0];
            quo_in = {quo_ff[LEVEL_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[LUX_W-2:0], quo_ff[LEVEL_W-1]};
            quo_in = {quo_ff[LEVEL_W-2:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff + 1'b1;
      end

      if (cmd.adj) begin
         res_level_in = adj_sum[LEVEL_W-1:0];
         res_dflt_in  = 1'b0;
      end

      if (cmd.load_out) begin
         out_level_in = res_level_ff;
         out_dflt_in  = res_dflt_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      lux_ff       <= lux_in;
      x0_ff        <= x0_in;
      y0_ff        <= y0_in;
      dy_neg_ff    <= dy_neg_in;
      dy_mag_ff    <= dy_mag_in;
      dx_ff        <= dx_in;
      dl_ff        <= dl_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      div_cnt_ff   <= div_cnt_in;
      res_level_ff <= res_level_in;
      res_dflt_ff  <= res_dflt_in;
      out_level_ff <= out_level_in;
      out_dflt_ff  <= out_dflt_in;
   end

   assign rsp_brightness   = out_level_ff;
   assign rsp_used_default = out_dflt_ff;

endmodule

`default_nettype wire

@@ rtl/piecewise_linear_brightness_curve.sv @@
// channel  | dir | handshake               | payload
// ---------+-----+-------------------------+---------------------------------------------
// req_ch   | in  | valid/ready             | operation, point_index, point_lux,
//          |     |                         | point_level, query_lux
// rsp_ch   | out | valid/ready             | brightness, used_default
// csr      | in  | csr_wr_en, no back-pres | csr_index, csr_wr_data
//
// a point write is done in the idle state; an interpolated query scans the table one entry
// per cycle over the points up to its segment (2 to MAX_POINTS of them), then multiplies,
// runs the 16-step radix-2 divider and fixes the sign; a query that ends on the default or
// the last level skips the multiply, divide and sign fix, and an empty curve skips the scan
// synchronous active-high reset clears the controller and the csr registers; the
// point table is not cleared and must be written before it is queried
// a finished result waits in the output register, so the next transaction is taken
// while rsp_ch stalls; the controller only blocks when a second result is ready
`default_nettype none

module piecewise_linear_brightness_curve
   import plbc_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   plbc_req_if.sink                   req_ch,
   plbc_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   // configuration registers
   logic [COUNT_W-1:0] point_count_ff, point_count_in;
   logic [LEVEL_W-1:0] default_level_ff, default_level_in;

   // controller <-> datapath
   cmd_type    cmd;
   status_type status;

   // csr decode; the user must write only while the block is idle, the block itself does not enforce it
   always_comb begin
      point_count_in   = point_count_ff;
      default_level_in = default_level_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POINT_COUNT:   point_count_in   = csr_wr_data[COUNT_W-1:0];
            CSR_DEFAULT_LEVEL: default_level_in = csr_wr_data[LEVEL_W-1:0];
            default: begin
               point_count_in   = point_count_ff;
               default_level_in = default_level_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff   <= '0;
         default_level_ff <= '0;
      end else begin
         point_count_ff   <= point_count_in;
         default_level_ff <= default_level_in;
      end
   end

   // sequencer: idle, table scan, multiply, divide, sign fix, result hand-off
   plbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.operation),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // point table, segment registers, multiplier, divider and output register
   plbc_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .point_index      (req_ch.point_index),
      .point_lux        (req_ch.point_lux),
      .point_level      (req_ch.point_level),
      .query_lux        (req_ch.query_lux),
      .point_count      (point_count_ff),
      .default_level    (default_level_ff),
      .rsp_brightness   (rsp_ch.brightness),
      .rsp_used_default (rsp_ch.used_default)
   );

`ifndef SYNTHESIS
   // a result is never loaded over one still waiting on rsp_ch
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result register overwritten");

   // a valid segment hit goes straight to the multiplier
   a_hit_to_mul : assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && status.hit && !status.seg_bad) |=> cmd.mul)
      else $error("segment hit did not start the multiply");

   // commands from the sequencer are mutually exclusive
   a_cmd_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr, cmd.start, cmd.scan_step, cmd.mul, cmd.div_step,
                cmd.adj, cmd.load_out}))
      else $error("overlapping datapath commands");

   // a fallback result carries the configured default level
   a_default_value : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.used_default) |-> (rsp_ch.brightness == default_level_ff))
      else $error("fallback result differs from default level");
`endif

endmodule

`default_nettype wire

@@ tb/sv/piecewise_linear_brightness_curve_test.sv @@
`timescale 1ns / 100ps

module piecewise_linear_brightness_curve_test;
   import plbc_pkg::*;

   localparam int MAX_POINTS    = MAX_POINTS_DEF;
   localparam int LUX_MAX       = (1 << LUX_W) - 1;
   localparam int LEVEL_MAX     = (1 << LEVEL_W) - 1;
   localparam int COUNT_MAX     = (1 << COUNT_W) - 1;
   localparam int RANDOM_ITEMS  = 1650;
   // settle time after draining, covers anything still in flight
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int IDLE_PERCENT  = 22;

   // one request transaction as offered on req_ch
   typedef struct packed {
      logic               operation;
      logic [INDEX_W-1:0] point_index;
      logic [LUX_W-1:0]   point_lux;
      logic [LEVEL_W-1:0] point_level;
      logic [LUX_W-1:0]   query_lux;
   } light_txn_type;

   // one response transaction as expected on rsp_ch
   typedef struct packed {
      logic [LEVEL_W-1:0] brightness;
      logic               used_default;
   } brightness_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   plbc_req_if req_if ();
   plbc_rsp_if rsp_if ();

   piecewise_linear_brightness_curve #(
      .MAX_POINTS (MAX_POINTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // predictor copy of the curve table and the registers
   logic [LUX_W-1:0]   curve_lux   [MAX_POINTS];
   logic [LEVEL_W-1:0] curve_level [MAX_POINTS];
   logic [COUNT_W-1:0] cfg_point_count;
   logic [LEVEL_W-1:0] cfg_default_level;

   light_txn_type  txn_backlog[$];     // transactions waiting to be offered
   brightness_type brightness_due[$];  // responses owed by accepted queries
   light_txn_type  offered;            // transaction currently on req_ch

   bit steady;          // no random idling on either side while set
   int hold_asks;       // bumped by the stimulus to ask for a long response stall
   int hold_seen;
   int hold_left;
   int errors;
   int items_queued;
   int cycle_count;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // scan the points in order, stop at the first one above the query lux,
   // then interpolate between it and the point before
   function automatic brightness_type map_lux_to_brightness(input logic [LUX_W-1:0] lux);
      int unsigned n;
      int unsigned prev;
      longint      y0;
      longint      dy;
      longint      dx;
      longint      dl;
      longint      v;
      brightness_type r;
      n = (cfg_point_count > MAX_POINTS) ? MAX_POINTS : cfg_point_count;
      prev = 0;
      r.brightness = cfg_default_level;
      r.used_default = 1'b1;
      for (int i = 0; i < n; i++) begin
         if (lux < curve_lux[i]) begin
            // below the first point lands here too, since prev is the same point
            if (curve_lux[i] <= curve_lux[prev]) begin
               r.brightness = cfg_default_level;
               r.used_default = 1'b1;
            end else begin
               y0 = longint'(curve_level[prev]);
               dy = longint'(curve_level[i]) - y0;
               dx = longint'(curve_lux[i]) - longint'(curve_lux[prev]);
               dl = longint'(lux) - longint'(curve_lux[prev]);
               // multiply first, division truncates toward zero
               v = (dy * dl) / dx + y0;
               if (v < 0) v = 0;
               if (v > LEVEL_MAX) v = LEVEL_MAX;
               r.brightness = v[LEVEL_W-1:0];
               r.used_default = 1'b0;
            end
            return r;
         end
         prev = i;
         r.brightness = curve_level[i];
         r.used_default = 1'b0;
      end
      return r;
   endfunction

   task automatic queue_point(input int slot, input int lux, input int level);
      light_txn_type t;
      t.operation = OP_WRITE;
      t.point_index = slot[INDEX_W-1:0];
      t.point_lux = lux[LUX_W-1:0];
      t.point_level = level[LEVEL_W-1:0];
      // ignored on a write, randomized anyway
      t.query_lux = $urandom;
      txn_backlog.push_back(t);
      items_queued++;
   endtask

   task automatic queue_query(input int lux);
      light_txn_type t;
      t.operation = OP_QUERY;
      // ignored on a query, randomized anyway
      t.point_index = $urandom;
      t.point_lux = $urandom;
      t.point_level = $urandom;
      t.query_lux = lux[LUX_W-1:0];
      txn_backlog.push_back(t);
      items_queued++;
   endtask

   // register write, only called while the block is idle
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int data);
      if (idx == CSR_POINT_COUNT) begin
         cfg_point_count = data[COUNT_W-1:0];
      end else begin
         cfg_default_level = data[LEVEL_W-1:0];
      end
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // everything offered and answered, then let a trailing write finish
   task automatic wait_drained();
      while (txn_backlog.size() != 0 || req_if.valid || brightness_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // driver: feeds req_ch from the backlog, and every accepted transaction
   // goes through the predictor in acceptance order
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (offered.operation == OP_WRITE) begin
               curve_lux[offered.point_index] = offered.point_lux;
               curve_level[offered.point_index] = offered.point_level;
            end else begin
               brightness_due.push_back(map_lux_to_brightness(offered.query_lux));
            end
         end
         // the slot is free when nothing is offered or the offer was just taken
         if (!req_if.valid || req_if.ready) begin
            if (txn_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
               offered = txn_backlog.pop_front();
               req_if.valid <= 1'b1;
               req_if.operation <= offered.operation;
               req_if.point_index <= offered.point_index;
               req_if.point_lux <= offered.point_lux;
               req_if.point_level <= offered.point_level;
               req_if.query_lux <= offered.query_lux;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each response against the oldest expectation and
   // drives ready, with random stalls and the occasional long hold-off
   always @(posedge clock) begin
      brightness_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (brightness_due.size() == 0) begin
               $error("response with no query waiting: brightness %h, used_default %b",
                      rsp_if.brightness, rsp_if.used_default);
               errors++;
            end else begin
               want = brightness_due.pop_front();
               if (rsp_if.brightness !== want.brightness) begin
                  $error("brightness: expected %h, actual %h", want.brightness,
                         rsp_if.brightness);
                  errors++;
               end
               if (rsp_if.used_default !== want.used_default) begin
                  $error("used_default: expected %b, actual %b", want.used_default,
                         rsp_if.used_default);
                  errors++;
               end
            end
         end
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      int phase;
      int pick;
      int count;
      int n_eff;
      int shape;
      int start;
      int maxinc;
      int k;
      int nq;
      int lux;
      int level;
      int directed_items;
      int plan_lux [MAX_POINTS];

      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.operation = OP_WRITE;
      req_if.point_index = '0;
      req_if.point_lux = '0;
      req_if.point_level = '0;
      req_if.query_lux = '0;
      rsp_if.ready = 1'b0;
      cfg_point_count = '0;
      cfg_default_level = '0;
      steady = 1'b0;
      hold_asks = 0;
      hold_seen = 0;
      hold_left = 0;
      errors = 0;
      items_queued = 0;
      cycle_count = 0;
      phase = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty curve: default level whatever the lux
      csr_write(CSR_DEFAULT_LEVEL, LEVEL_MAX);
      csr_write(CSR_POINT_COUNT, 0);
      queue_query(0);
      queue_query(LUX_MAX);

      // fill every slot so no later scan can touch an unwritten entry;
      // the last point sits at full-scale lux and level, levels go up and down
      for (int i = 0; i < MAX_POINTS; i++) begin
         lux = (i == 0) ? 16 : i * (LUX_MAX / (MAX_POINTS - 1));
         if (i == MAX_POINTS - 1) level = LEVEL_MAX;
         else if (i % 2 == 1) level = 16'hF000 - i * 256;
         else level = i * 512;
         queue_point(i, lux, level);
      end
      wait_drained();

      csr_write(CSR_POINT_COUNT, MAX_POINTS);
      queue_query(0);                               // below the first point
      queue_query(16);                              // exactly on the first point
      queue_query(LUX_MAX);                         // at the last point
      queue_query(LUX_MAX / (MAX_POINTS - 1) - 1);  // rising segment
      queue_query(LUX_MAX / (MAX_POINTS - 1) + 300);  // falling segment
      queue_query(20'h88888);
      wait_drained();

      // count above the table size acts as a full table
      csr_write(CSR_POINT_COUNT, COUNT_MAX);
      queue_query(20'hC0000);
      directed_items = items_queued;

      // random phases: a fresh setting, a curve written slot by slot, then
      // queries aimed at the points, the segments and both ends, with a few
      // stray rewrites that bend the curve mid-phase
      while (items_queued - directed_items < RANDOM_ITEMS) begin
         wait_drained();
         phase++;
         steady = (phase >= 5 && phase <= 8);

         pick = $urandom_range(9);
         case (pick)
            0: count = 0;
            1: count = MAX_POINTS;
            2: count = COUNT_MAX;
            3: count = $urandom_range(COUNT_MAX - 1, MAX_POINTS + 1);
            default: count = $urandom_range(MAX_POINTS, 1);
         endcase
         csr_write(CSR_POINT_COUNT, count);
         pick = $urandom_range(7);
         if (pick == 0) csr_write(CSR_DEFAULT_LEVEL, 0);
         else if (pick == 1) csr_write(CSR_DEFAULT_LEVEL, LEVEL_MAX);
         else csr_write(CSR_DEFAULT_LEVEL, $urandom & LEVEL_MAX);
         n_eff = (count > MAX_POINTS) ? MAX_POINTS : count;

         // curve shape: mostly rising lux, sometimes a repeated or falling
         // point, now and then plain random
         shape = $urandom_range(9);
         start = ($urandom_range(3) == 0) ? 0 : $urandom_range(LUX_MAX / 2);
         maxinc = (LUX_MAX - start) / ((n_eff == 0) ? 1 : n_eff);
         for (int i = 0; i < n_eff; i++) begin
            if (shape == 9) plan_lux[i] = $urandom & LUX_MAX;
            else if (i == 0) plan_lux[i] = start;
            else plan_lux[i] = plan_lux[i-1] + $urandom_range(maxinc, 1);
         end
         if (n_eff > 1 && (shape == 7 || shape == 8)) begin
            k = $urandom_range(n_eff - 1, 1);
            if (shape == 7) plan_lux[k] = plan_lux[k-1];
            else plan_lux[k] = plan_lux[k-1] - $urandom_range(plan_lux[k-1]);
         end
         for (int i = 0; i < n_eff; i++) begin
            pick = $urandom_range(7);
            if (pick == 0) level = 0;
            else if (pick == 1) level = LEVEL_MAX;
            else level = $urandom & LEVEL_MAX;
            queue_point(i, plan_lux[i], level);
         end
         // a write past the active points changes nothing visible
         if (n_eff < MAX_POINTS && $urandom_range(3) == 0) begin
            queue_point($urandom_range(MAX_POINTS - 1, n_eff), $urandom, $urandom);
         end

         // once: hold off responses long enough that the block stalls its input
         if (phase == 2) hold_asks++;

         nq = $urandom_range(40, 10);
         for (int q = 0; q < nq; q++) begin
            // once: the sender stops until every response is in
            if (phase == 3 && q == nq / 2) wait_drained();
            if ($urandom_range(99) < 8) begin
               k = $urandom_range(MAX_POINTS - 1);
               lux = $urandom & LUX_MAX;
               if (k < n_eff) plan_lux[k] = lux;
               queue_point(k, lux, $urandom);
            end else begin
               pick = $urandom_range(9);
               if (n_eff == 0 || pick >= 8) begin
                  lux = $urandom & LUX_MAX;
               end else begin
                  k = $urandom_range(n_eff - 1);
                  case (pick)
                     0, 1: lux = plan_lux[k];
                     2: lux = (plan_lux[k] - 1) & LUX_MAX;
                     3: lux = (plan_lux[k] + 1) & LUX_MAX;
                     4, 5: begin
                        if (k + 1 < n_eff && plan_lux[k+1] > plan_lux[k]) begin
                           lux = plan_lux[k] + $urandom_range(plan_lux[k+1] - plan_lux[k] - 1);
                        end else begin
                           lux = plan_lux[k];
                        end
                     end
                     6: lux = (plan_lux[0] == 0) ? 0 : $urandom_range(plan_lux[0] - 1);
                     default: begin
                        lux = plan_lux[n_eff-1] + $urandom_range(LUX_MAX - plan_lux[n_eff-1]);
                     end
                  endcase
               end
               queue_query(lux);
            end
         end
      end

      steady = 1'b0;
      wait_drained();
      if (errors == 0 && brightness_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/plbc_pkg.sv
rtl/plbc_req_if.sv
rtl/plbc_rsp_if.sv
rtl/plbc_ctrl.sv
rtl/plbc_dp.sv
rtl/piecewise_linear_brightness_curve.sv
tb/sv/piecewise_linear_brightness_curve_test.sv
